// ===== hdl/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared sizes, codes and helpers for the text console engine.
// ----------------------------------------------------------------------------
package tce_pkg;

	// screen geometry
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int NCELLS = ROWS * COLS;

	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(NCELLS);

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int CELL_W = 2 * BYTE_W;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

	// control characters
	localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
	localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam int TAB_STEP = 8;

	localparam logic [BYTE_W-1:0] DEFAULT_COLOR_RST = 8'd7;

	// one write into the screen store
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

	// blank cell: space in the given attribute
	function automatic logic [CELL_W-1:0] blank_cell(input logic [BYTE_W-1:0] attr);
		return {attr, CH_SPACE};
	endfunction

endpackage

// ===== hdl/tce_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tce_screen_ram
// Screen store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tce_screen_ram (
	input  logic                                clk,
	input  tce_pkg::ram_wr_t                    wr,
	input  logic [tce_pkg::ADDR_W-1:0]          rd_addr,
	output logic [tce_pkg::CELL_W-1:0]          rd_data
);

	logic [tce_pkg::CELL_W-1:0] mem [tce_pkg::NCELLS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hdl/tce_addr_unit.sv =====
// ----------------------------------------------------------------------------
// tce_addr_unit
// Maps a logical row and column to a store address through the top-line
// offset, which makes a scroll a pointer move instead of a copy.
// ----------------------------------------------------------------------------
module tce_addr_unit (
	input  logic [tce_pkg::ROW_W-1:0]  row,
	input  logic [tce_pkg::COL_W-1:0]  col,
	input  logic [tce_pkg::ROW_W-1:0]  top,
	output logic [tce_pkg::ADDR_W-1:0] addr
);

	logic [tce_pkg::ROW_W:0]   row_sum;
	logic [tce_pkg::ROW_W-1:0] phys_row;

	always_comb begin
		row_sum = {1'b0, row} + {1'b0, top};
		// wrap around the circular line buffer
		if (row_sum >= (tce_pkg::ROW_W+1)'(tce_pkg::ROWS)) begin
			row_sum = row_sum - (tce_pkg::ROW_W+1)'(tce_pkg::ROWS);
		end
		phys_row = row_sum[tce_pkg::ROW_W-1:0];
		addr = tce_pkg::ADDR_W'(phys_row) * tce_pkg::ADDR_W'(tce_pkg::COLS)
			+ tce_pkg::ADDR_W'(col);
	end

endmodule

// ===== hdl/text_console_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_engine
// Text console: screen store of character/attribute cells, cursor, and a
// small sequencer that drives one shared address unit and the store.
// ----------------------------------------------------------------------------
// Steps per item: a set cursor goes straight to the result; a put writes
// its cell and, when it scrolls, then blanks the new last line; a read
// subtracts COLS once per row of the cell and then reads it (an index
// past the store goes straight to the result); a clear blanks all NCELLS
// cells. A stalled result holds the sequencer in its done state. One item
// at a time: in_stall stays high until the item's result has been issued.
// Reset: asynchronous, active low; after it a clearing pass writes all
// NCELLS cells blank in attribute 7, with in_stall high during the pass.
// ----------------------------------------------------------------------------
module text_console_engine (
	input  logic                              clk,
	input  logic                              arst_n,

	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tce_pkg::BYTE_W-1:0]        default_color,

	// input item channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tce_pkg::FUNC_W-1:0]        func,
	input  logic [tce_pkg::BYTE_W-1:0]        char_code,
	input  logic [tce_pkg::BYTE_W-1:0]        color,
	input  logic signed [tce_pkg::BYTE_W-1:0] row,
	input  logic signed [tce_pkg::BYTE_W-1:0] column,
	input  logic [tce_pkg::IDX_W-1:0]         cell_index,

	// result item channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tce_pkg::POS_W-1:0]         cursor_pos,
	output logic [tce_pkg::BYTE_W-1:0]        cell_char,
	output logic [tce_pkg::BYTE_W-1:0]        cell_attr
);

	localparam int COL_W  = tce_pkg::COL_W;
	localparam int ROW_W  = tce_pkg::ROW_W;
	localparam int ADDR_W = tce_pkg::ADDR_W;
	localparam int BYTE_W = tce_pkg::BYTE_W;
	localparam int IDX_W  = tce_pkg::IDX_W;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SWEEP  = 3'd1;
	localparam logic [2:0] S_PUT    = 3'd2;
	localparam logic [2:0] S_SCROLL = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_RDWAIT = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] cnt_q;          // sweep address, or column on scroll
	logic [BYTE_W-1:0] sweep_attr_q;   // blanking attribute, held for a pass
	logic              sweep_item_q;   // clearing pass belongs to an item
	logic [BYTE_W-1:0] dflt_color_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  top_q;          // physical row shown as logical row 0

	// item payload and read-back scratch
	logic [BYTE_W-1:0] char_q;
	logic [BYTE_W-1:0] color_q;
	logic [IDX_W-1:0]  rem_q;
	logic [ROW_W-1:0]  rd_row_q;
	logic [BYTE_W-1:0] rd_char_q;
	logic [BYTE_W-1:0] rd_attr_q;

	// result register
	logic                      out_valid_q;
	logic [tce_pkg::POS_W-1:0] cursor_pos_q;
	logic [BYTE_W-1:0]         cell_char_q;
	logic [BYTE_W-1:0]         cell_attr_q;

	logic accept;
	logic out_free;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

	// ------------------------------------------------------------------
	// Put: next cursor and the cell write, all from the held item
	// ------------------------------------------------------------------
	logic [COL_W:0]              put_col;
	logic [ROW_W:0]              put_row;
	logic [COL_W-1:0]            put_wr_col;
	logic                        put_wr_en;
	logic [tce_pkg::CELL_W-1:0]  put_wr_data;
	logic                        put_scroll;

	always_comb begin
		put_col     = {1'b0, cur_col_q};
		put_row     = {1'b0, cur_row_q};
		put_wr_col  = cur_col_q;
		put_wr_en   = 1'b0;
		put_wr_data = tce_pkg::blank_cell(color_q);
		case (char_q)
			tce_pkg::CH_NL: begin
				put_row = put_row + 1'b1;
				put_col = '0;
			end
			tce_pkg::CH_CR: begin
				put_col = '0;
			end
			tce_pkg::CH_TAB: begin
				put_col = (put_col + (COL_W+1)'(tce_pkg::TAB_STEP))
					& ~(COL_W+1)'(tce_pkg::TAB_STEP - 1);
			end
			tce_pkg::CH_BS: begin
				// at column 0 nothing changes
				if (cur_col_q != '0) begin
					put_wr_col = cur_col_q - 1'b1;
					put_wr_en  = 1'b1;
					put_col    = put_col - 1'b1;
				end
			end
			default: begin
				put_wr_en   = 1'b1;
				put_wr_data = {color_q, char_q};
				put_col     = put_col + 1'b1;
			end
		endcase
		// wrap at the line end
		if (put_col >= (COL_W+1)'(tce_pkg::COLS)) begin
			put_col = '0;
			put_row = put_row + 1'b1;
		end
		put_scroll = (put_row >= (ROW_W+1)'(tce_pkg::ROWS));
	end

	// ------------------------------------------------------------------
	// Shared address unit: input select per state
	// ------------------------------------------------------------------
	logic [ROW_W-1:0]  au_row;
	logic [COL_W-1:0]  au_col;
	logic [ADDR_W-1:0] au_addr;

	always_comb begin
		case (state_q)
			S_SCROLL: begin
				au_row = ROW_W'(tce_pkg::ROWS - 1);
				au_col = cnt_q[COL_W-1:0];
			end
			S_DIV: begin
				au_row = rd_row_q;
				au_col = rem_q[COL_W-1:0];
			end
			default: begin
				au_row = cur_row_q;
				au_col = put_wr_col;
			end
		endcase
	end

	tce_addr_unit u_addr (
		.row  (au_row),
		.col  (au_col),
		.top  (top_q),
		.addr (au_addr)
	);

	// ------------------------------------------------------------------
	// Screen store
	// ------------------------------------------------------------------
	tce_pkg::ram_wr_t           ram_wr;
	logic [tce_pkg::CELL_W-1:0] ram_rd_data;

	always_comb begin
		ram_wr.en   = 1'b0;
		ram_wr.addr = au_addr;
		ram_wr.data = tce_pkg::blank_cell(sweep_attr_q);
		case (state_q)
			S_SWEEP: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = cnt_q;
			end
			S_SCROLL: begin
				ram_wr.en = 1'b1;
			end
			S_PUT: begin
				ram_wr.en   = put_wr_en;
				ram_wr.data = put_wr_data;
			end
			default: begin
				ram_wr.en = 1'b0;
			end
		endcase
	end

	tce_screen_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr (au_addr),
		.rd_data (ram_rd_data)
	);

	// ------------------------------------------------------------------
	// Set-cursor clamps
	// ------------------------------------------------------------------
	logic [ROW_W-1:0] set_row;
	logic [COL_W-1:0] set_col;

	always_comb begin
		if (row[BYTE_W-1]) begin
			set_row = '0;
		end else if (row > BYTE_W'(tce_pkg::ROWS - 1)) begin
			set_row = ROW_W'(tce_pkg::ROWS - 1);
		end else begin
			set_row = ROW_W'(row);
		end
		if (column[BYTE_W-1]) begin
			set_col = '0;
		end else if (column > BYTE_W'(tce_pkg::COLS - 1)) begin
			set_col = COL_W'(tce_pkg::COLS - 1);
		end else begin
			set_col = COL_W'(column);
		end
	end

	logic [ADDR_W:0] pos_calc;
	assign pos_calc = (ADDR_W+1)'(cur_row_q) * (ADDR_W+1)'(tce_pkg::COLS)
		+ (ADDR_W+1)'(cur_col_q);

	logic read_in_range;
	assign read_in_range = (32'(cell_index) < 32'(tce_pkg::NCELLS));

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			cnt_q        <= '0;
			sweep_attr_q <= tce_pkg::DEFAULT_COLOR_RST;
			sweep_item_q <= 1'b0;
			dflt_color_q <= tce_pkg::DEFAULT_COLOR_RST;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			top_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dflt_color_q <= default_color;
			end
			// drop the result once taken, unless the next one replaces it
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func)
							tce_pkg::FUNC_PUT: begin
								state_q <= S_PUT;
							end
							tce_pkg::FUNC_SET: begin
								cur_row_q <= set_row;
								cur_col_q <= set_col;
								state_q   <= S_DONE;
							end
							tce_pkg::FUNC_CLEAR: begin
								cnt_q        <= '0;
								sweep_attr_q <= dflt_color_q;
								sweep_item_q <= 1'b1;
								top_q        <= '0;
								cur_row_q    <= '0;
								cur_col_q    <= '0;
								state_q      <= S_SWEEP;
							end
							default: begin
								state_q <= read_in_range ? S_DIV : S_DONE;
							end
						endcase
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(tce_pkg::NCELLS - 1)) begin
						state_q <= sweep_item_q ? S_DONE : S_IDLE;
					end
				end
				S_PUT: begin
					cur_col_q <= put_col[COL_W-1:0];
					if (put_scroll) begin
						// advance the top line; old top becomes the new last line
						cur_row_q    <= ROW_W'(tce_pkg::ROWS - 1);
						top_q        <= (top_q == ROW_W'(tce_pkg::ROWS - 1)) ?
							'0 : top_q + 1'b1;
						cnt_q        <= '0;
						sweep_attr_q <= dflt_color_q;
						state_q      <= S_SCROLL;
					end else begin
						cur_row_q <= put_row[ROW_W-1:0];
						state_q   <= S_DONE;
					end
				end
				S_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(tce_pkg::COLS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					// one row per cycle; the read issues once the remainder fits
					if (!(rem_q < IDX_W'(tce_pkg::COLS))) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_RDWAIT;
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload, read-back scratch and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					char_q    <= char_code;
					color_q   <= color;
					rem_q     <= cell_index;
					rd_row_q  <= '0;
					rd_char_q <= '0;
					rd_attr_q <= '0;
				end
			end
			S_DIV: begin
				if (!(rem_q < IDX_W'(tce_pkg::COLS))) begin
					rem_q    <= rem_q - IDX_W'(tce_pkg::COLS);
					rd_row_q <= rd_row_q + 1'b1;
				end
			end
			S_RDWAIT: begin
				rd_char_q <= ram_rd_data[BYTE_W-1:0];
				rd_attr_q <= ram_rd_data[2*BYTE_W-1:BYTE_W];
			end
			S_DONE: begin
				if (out_free) begin
					cursor_pos_q <= tce_pkg::POS_W'(pos_calc);
					cell_char_q  <= rd_char_q;
					cell_attr_q  <= rd_attr_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule

// ===== dv/text_console_engine_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_engine testbench
// Drives put, set-cursor, clear and read items into the console engine and
// checks every returned cursor position and cell against a shadow screen
// in the bench or a typed row's own expectation. A short table of directed
// items comes first, then random phases split by default colour writes.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tce_pkg::*;

	// one item as it crosses the input channel
	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [BYTE_W-1:0]        char_code;
		logic [BYTE_W-1:0]        color;
		logic signed [BYTE_W-1:0] row;
		logic signed [BYTE_W-1:0] column;
		logic [IDX_W-1:0]         cell_index;
	} console_item_t;

	// one item as it comes back on the result channel
	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [BYTE_W-1:0] cell_char;
		logic [BYTE_W-1:0] cell_attr;
	} console_view_t;

	// a stimulus row: the item plus an optional hand-written expectation
	typedef struct packed {
		console_item_t item;
		logic          typed;
		console_view_t want;
	} console_stim_t;

	localparam int RANDOM_PHASES    = 5;
	localparam int ITEMS_PER_PHASE  = 150;
	localparam int MAX_WAIT         = 12;
	localparam int LONG_HOLD        = 300;
	localparam int LONG_HOLD_AT     = 60;
	localparam int REPORT_LIMIT     = 10;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [BYTE_W-1:0]        default_color;
	logic                     in_valid;
	logic                     in_stall;
	logic [FUNC_W-1:0]        func;
	logic [BYTE_W-1:0]        char_code;
	logic [BYTE_W-1:0]        color;
	logic signed [BYTE_W-1:0] row;
	logic signed [BYTE_W-1:0] column;
	logic [IDX_W-1:0]         cell_index;
	logic                     out_valid;
	logic                     out_stall;
	logic [POS_W-1:0]         cursor_pos;
	logic [BYTE_W-1:0]        cell_char;
	logic [BYTE_W-1:0]        cell_attr;

	// shadow copy of the console: screen store, cursor and blanking colour
	logic [CELL_W-1:0] shadow_screen [NCELLS];
	int                shadow_row;
	int                shadow_col;
	logic [BYTE_W-1:0] shadow_blank_attr;

	console_view_t pending_views [$];
	console_stim_t directed_items [$];
	int            mismatch_count;

	text_console_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.default_color (default_color),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.char_code     (char_code),
		.color         (color),
		.row           (row),
		.column        (column),
		.cell_index    (cell_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cursor_pos    (cursor_pos),
		.cell_char     (cell_char),
		.cell_attr     (cell_attr)
	);

	// 100 MHz clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Blank every cell in the current default colour and home the cursor.
	function automatic void blank_shadow_screen();
		for (int i = 0; i < NCELLS; i++) begin
			shadow_screen[i] = {shadow_blank_attr, CH_SPACE};
		end
		shadow_row = 0;
		shadow_col = 0;
	endfunction

	// Apply one item to the shadow console and return the view the block
	// should report for it.
	function automatic console_view_t predict_console(input console_item_t it);
		console_view_t     view;
		int                req_row;
		int                req_col;
		logic [CELL_W-1:0] cell_word;
		view = '0;
		case (it.func)
			FUNC_PUT: begin
				if (it.char_code == CH_BS) begin
					// backspace: step back and blank, no wrap and no scroll;
					// at column 0 nothing happens
					if (shadow_col > 0) begin
						shadow_col--;
						shadow_screen[shadow_row * COLS + shadow_col] = {it.color, CH_SPACE};
					end
				end else begin
					if (it.char_code == CH_NL) begin
						shadow_row++;
						shadow_col = 0;
					end else if (it.char_code == CH_CR) begin
						shadow_col = 0;
					end else if (it.char_code == CH_TAB) begin
						shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
					end else begin
						shadow_screen[shadow_row * COLS + shadow_col] = {it.color, it.char_code};
						shadow_col++;
					end
					// wrap at line end, a tab included
					if (shadow_col >= COLS) begin
						shadow_col = 0;
						shadow_row++;
					end
					// past the last row: shift up one line, blank the bottom line,
					// park on the last row and keep the column
					if (shadow_row >= ROWS) begin
						for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
							shadow_screen[i] = shadow_screen[i + COLS];
						end
						for (int i = (ROWS - 1) * COLS; i < NCELLS; i++) begin
							shadow_screen[i] = {shadow_blank_attr, CH_SPACE};
						end
						shadow_row = ROWS - 1;
					end
				end
			end
			FUNC_SET: begin
				// clamp the signed request into the screen
				req_row = int'($signed(it.row));
				req_col = int'($signed(it.column));
				if (req_row < 0) req_row = 0;
				if (req_row > ROWS - 1) req_row = ROWS - 1;
				if (req_col < 0) req_col = 0;
				if (req_col > COLS - 1) req_col = COLS - 1;
				shadow_row = req_row;
				shadow_col = req_col;
			end
			FUNC_CLEAR: begin
				blank_shadow_screen();
			end
			default: begin
				// read: an index past the store returns zeros
				if (int'(it.cell_index) < NCELLS) begin
					cell_word = shadow_screen[it.cell_index];
					view.cell_char = cell_word[BYTE_W-1:0];
					view.cell_attr = cell_word[CELL_W-1:BYTE_W];
				end
			end
		endcase
		view.cursor_pos = POS_W'(shadow_row * COLS + shadow_col);
		return view;
	endfunction

	// Build a random item. Most items are printable puts and reads near the
	// cursor, so that the screen fills, scrolls and gets read back; the rest
	// are control codes, cursor moves, raw bytes, other reads and the odd clear.
	function automatic console_item_t random_console_item();
		console_item_t it;
		int            pick;
		int            near_idx;
		it.func       = FUNC_PUT;
		it.char_code  = BYTE_W'($urandom_range(0, 255));
		it.color      = BYTE_W'($urandom_range(0, 255));
		it.row        = BYTE_W'($urandom_range(0, 255));
		it.column     = BYTE_W'($urandom_range(0, 255));
		it.cell_index = IDX_W'($urandom_range(0, 2047));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			// printable text, with a raw byte now and then
			if ($urandom_range(0, 3) != 0) begin
				it.char_code = BYTE_W'($urandom_range(8'h21, 8'h7e));
			end
		end else if (pick < 66) begin
			case ($urandom_range(0, 3))
				0:       it.char_code = CH_NL;
				1:       it.char_code = CH_CR;
				2:       it.char_code = CH_TAB;
				default: it.char_code = CH_BS;
			endcase
		end else if (pick < 76) begin
			it.func = FUNC_SET;
			// in-range moves lean to the bottom rows to provoke scrolls
			if ($urandom_range(0, 9) < 6) begin
				it.row    = BYTE_W'($urandom_range(0, 1) != 0 ?
					$urandom_range(ROWS - 3, ROWS - 1) : $urandom_range(0, ROWS - 1));
				it.column = BYTE_W'($urandom_range(0, 1) != 0 ?
					$urandom_range(COLS - 10, COLS - 1) : $urandom_range(0, COLS - 1));
			end
		end else if (pick < 98) begin
			it.func = FUNC_READ;
			// mostly read back what was just written above the cursor
			if ($urandom_range(0, 9) < 7) begin
				near_idx = shadow_row * COLS + shadow_col - $urandom_range(0, 2 * COLS);
				if (near_idx < 0) near_idx = $urandom_range(0, COLS);
				it.cell_index = IDX_W'(near_idx);
			end else if ($urandom_range(0, 2) != 0) begin
				it.cell_index = IDX_W'($urandom_range(0, NCELLS - 1));
			end
		end else begin
			it.func = FUNC_CLEAR;
		end
		return it;
	endfunction

	// Queue one directed row; a typed row carries its own expectation.
	task automatic add_directed(input logic [FUNC_W-1:0] f, input int ch, input int attr,
			input int r, input int c, input int idx, input logic typed,
			input int pos, input int want_ch, input int want_attr);
		console_stim_t s;
		s.item.func         = f;
		s.item.char_code    = BYTE_W'(ch);
		s.item.color        = BYTE_W'(attr);
		s.item.row          = BYTE_W'(r);
		s.item.column       = BYTE_W'(c);
		s.item.cell_index   = IDX_W'(idx);
		s.typed             = typed;
		s.want.cursor_pos   = POS_W'(pos);
		s.want.cell_char    = BYTE_W'(want_ch);
		s.want.cell_attr    = BYTE_W'(want_attr);
		directed_items.push_back(s);
	endtask

	// Offer one item, starting from a falling edge; return on the falling
	// edge after it has been taken. The expectation is logged at acceptance.
	task automatic send_item(input console_stim_t s, input bit no_gap);
		int            gap;
		console_view_t view;
		gap = no_gap ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func       = s.item.func;
		char_code  = s.item.char_code;
		color      = s.item.color;
		row        = s.item.row;
		column     = s.item.column;
		cell_index = s.item.cell_index;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
		view = predict_console(s.item);
		pending_views.push_back(s.typed ? s.want : view);
		@(negedge clk);
	endtask

	// Write the blanking colour; only called with the block idle.
	task automatic write_default_color(input logic [BYTE_W-1:0] value);
		@(negedge clk);
		default_color = value;
		cfg_valid     = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		shadow_blank_attr = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stimulus: reset, directed table, then random phases.
	initial begin
		console_stim_t s;
		logic [BYTE_W-1:0] phase_color;
		bit calm_tx;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		default_color = '0;
		in_valid      = 1'b0;
		func          = FUNC_PUT;
		char_code     = '0;
		color         = '0;
		row           = '0;
		column        = '0;
		cell_index    = '0;
		mismatch_count = 0;
		calm_tx       = 1'b0;

		shadow_blank_attr = DEFAULT_COLOR_RST;
		blank_shadow_screen();

		// hold reset, then release it away from the rising edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. The clearing pass after reset keeps in_stall high;
		// the first send simply waits it out.
		// reads of the fresh screen: blank in the reset colour, zeros past the end
		add_directed(FUNC_READ, 0, 0, 0, 0, 0, 1'b1, 0, CH_SPACE, DEFAULT_COLOR_RST);
		add_directed(FUNC_READ, 0, 0, 0, 0, NCELLS - 1, 1'b1, 0, CH_SPACE, DEFAULT_COLOR_RST);
		add_directed(FUNC_READ, 0, 0, 0, 0, NCELLS, 1'b1, 0, 0, 0);
		add_directed(FUNC_READ, 255, 255, -1, -1, 2047, 1'b1, 0, 0, 0);
		// cursor clamps at both extremes
		add_directed(FUNC_SET, 0, 0, -128, -128, 0, 1'b1, 0, 0, 0);
		add_directed(FUNC_SET, 0, 0, 127, 127, 0, 1'b1, NCELLS - 1, 0, 0);
		// print in the last cell: wrap, then scroll onto the last row
		add_directed(FUNC_PUT, 8'h41, 8'hff, 0, 0, 0, 1'b1, (ROWS - 1) * COLS, 0, 0);
		add_directed(FUNC_READ, 0, 0, 0, 0, (ROWS - 1) * COLS - 1, 1'b0, 0, 0, 0);
		add_directed(FUNC_READ, 0, 0, 0, 0, NCELLS - 1, 1'b0, 0, 0, 0);
		// backspace at column 0 changes nothing
		add_directed(FUNC_SET, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0);
		add_directed(FUNC_PUT, CH_BS, 8'h33, 0, 0, 0, 1'b1, 0, 0, 0);
		// extreme bytes, then backspace blanks in the item's colour
		add_directed(FUNC_PUT, 8'h00, 8'h00, 0, 0, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, 8'hff, 8'hff, 0, 0, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, CH_BS, 8'h5a, 0, 0, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_READ, 0, 0, 0, 0, 1, 1'b0, 0, 0, 0);
		add_directed(FUNC_READ, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		// tab stops, carriage return, newline
		add_directed(FUNC_PUT, CH_TAB, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, CH_TAB, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, CH_CR, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, CH_NL, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		// tab from the last column wraps to the next row
		add_directed(FUNC_SET, 0, 0, 3, COLS - 1, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, CH_TAB, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		// newline on the last row scrolls
		add_directed(FUNC_SET, 0, 0, ROWS - 1, 5, 0, 1'b0, 0, 0, 0);
		add_directed(FUNC_PUT, CH_NL, 0, 0, 0, 0, 1'b0, 0, 0, 0);
		// row too large with a negative column
		add_directed(FUNC_SET, 0, 0, 127, -1, 0, 1'b0, 0, 0, 0);
		// clear homes the cursor and blanks in the reset colour
		add_directed(FUNC_CLEAR, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0);
		add_directed(FUNC_READ, 0, 0, 0, 0, 0, 1'b1, 0, CH_SPACE, DEFAULT_COLOR_RST);

		foreach (directed_items[i]) begin
			send_item(directed_items[i], 1'b0);
		end
		in_valid = 1'b0;

		// Random phases; drain and rewrite the blanking colour in between.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			while (pending_views.size() != 0) @(posedge clk);
			case (p)
				0:       phase_color = 8'h00;
				1:       phase_color = 8'hff;
				default: phase_color = BYTE_W'($urandom_range(0, 255));
			endcase
			write_default_color(phase_color);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// switch between gappy and back-to-back stretches
				if (n % 30 == 0) calm_tx = ($urandom_range(0, 3) == 0);
				s.item  = random_console_item();
				s.typed = 1'b0;
				s.want  = '0;
				send_item(s, calm_tx);
			end
			in_valid = 1'b0;
		end

		// drain, then leave room for a stray result to show up
		while (pending_views.size() != 0) @(posedge clk);
		repeat (COLS + 10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Result side: random stalls per item, one long hold-off to back up the
	// block, and a field-by-field check against the oldest expectation.
	initial begin
		int            hold;
		int            seen;
		bit            calm_rx;
		console_view_t want;
		out_stall = 1'b0;
		seen      = 0;
		calm_rx   = 1'b0;
		forever begin
			if (seen % 40 == 0) calm_rx = ($urandom_range(0, 3) == 0);
			hold = calm_rx ? 0 : $urandom_range(0, MAX_WAIT);
			if (seen == LONG_HOLD_AT) hold = LONG_HOLD;
			@(negedge clk);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			seen++;
			if (pending_views.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("%t: result with nothing pending: pos %0d char %h attr %h",
						$realtime, cursor_pos, cell_char, cell_attr);
				end
			end else begin
				want = pending_views.pop_front();
				if (cursor_pos !== want.cursor_pos || cell_char !== want.cell_char ||
						cell_attr !== want.cell_attr) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%t: mismatch: pos %0d/%0d char %h/%h attr %h/%h (exp/got)",
							$realtime, want.cursor_pos, cursor_pos, want.cell_char,
							cell_char, want.cell_attr, cell_attr);
					end
				end
			end
		end
	end

	// Timeout guard.
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tce_pkg.sv
hdl/tce_screen_ram.sv
hdl/tce_addr_unit.sv
hdl/text_console_engine.sv
dv/text_console_engine_tb.sv
